### hw/rtl/rgb_convolution_3x3_normalized_defines.svh
// ------------------------------------------------------------------------
// rgb_convolution_3x3_normalized assertion macros
// Shared concurrent assertion forms for the filter block.
// ------------------------------------------------------------------------
`ifndef RGB_CONVOLUTION_3X3_NORMALIZED_DEFINES_SVH
`define RGB_CONVOLUTION_3X3_NORMALIZED_DEFINES_SVH

// same-cycle implication
`define RCN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rcn assertion failed");

// next-cycle implication
`define RCN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rcn assertion failed");

`endif

### hw/rtl/rcn_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rcn_pkg
// Types and fixed constants of the 3x3 RGB convolution filter.
// ------------------------------------------------------------------------
package rcn_pkg;

	localparam int KERNEL_W  = 45;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 45;
	localparam int TAP_W     = 5;
	localparam int TAPS      = 9;
	localparam int PIX_W     = 24;
	localparam int ACC_W     = 18;
	localparam int TSUM_W    = 9;
	localparam int MAG_W     = 16;
	localparam int DVS_W     = 8;
	localparam int STEP_W    = 4;
	localparam int CH_MAX    = 255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_MAC  = 6'b000100,
		S_PREP = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       filler;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} pix_out_t;

endpackage

### hw/rtl/rgb_convolution_3x3_normalized.sv
`timescale 1ns / 1ps
// A pixel that yields a result passes through read, nine multiply-accumulate
// steps, setup, 16 divide steps and output; output waits while out_stall holds.
// No new beat is taken until the last one is through (in_stall is high
// outside idle); the first width+1 beats of a frame only prime the line
// stores. The shared MAC and the bit-serial divider set the pace.
// Reset: counters and control clear at once; line stores need no clearing.
// ------------------------------------------------------------------------
// rgb_convolution_3x3_normalized
// 3x3 signed-kernel filter over an RGB raster stream, normalized by the
// tap sum and clamped to 0..255, with two line stores in RAM.
// ------------------------------------------------------------------------
`include "rgb_convolution_3x3_normalized_defines.svh"

module rgb_convolution_3x3_normalized import rcn_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pix_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pix_out_t             out_data
);

	localparam int CI_W = $clog2(MAX_WIDTH);
	localparam int FW_W = $clog2(MAX_WIDTH + 1);
	localparam int RI_W = $clog2(MAX_HEIGHT);
	localparam int FH_W = $clog2(MAX_HEIGHT + 1);
	localparam int PR_W = FW_W + 1;

	state_t                state_q;
	logic [KERNEL_W-1:0]   kernel_q;
	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	logic [FW_W-1:0]       frame_w_q;
	logic [FH_W-1:0]       frame_h_q;
	logic                  active_q;
	logic [CI_W-1:0]       col_cnt_q;
	logic [PR_W-1:0]       prime_q;
	logic [CI_W-1:0]       mx_q;
	logic [RI_W-1:0]       my_q;
	logic [PIX_W-1:0]      px_s1;
	logic [PIX_W-1:0]      win_q [6];
	logic [PIX_W-1:0]      col_q [3];
	logic [1:0]            dx_q;
	logic [1:0]            dy_q;
	logic [STEP_W-1:0]     tap_idx_q;
	logic signed [ACC_W-1:0]  acc_q [3];
	logic signed [TSUM_W-1:0] tsum_q;
	logic [2:0]            neg_q;
	logic [DVS_W-1:0]      rem_q [3];
	logic [MAG_W-1:0]      qd_q [3];
	logic [DVS_W-1:0]      dvs_q;
	logic [STEP_W-1:0]     step_q;
	logic                  out_valid_q;
	pix_out_t              out_q;

	logic [PIX_W-1:0]      rd_above;
	logic [PIX_W-1:0]      rd_two_above;
	logic                  ram_we;
	logic                  in_acc;
	logic [FW_W-1:0]       width_sat;
	logic [FH_W-1:0]       height_sat;
	logic                  col_last;
	logic                  mx_last;
	logic                  my_last;
	logic signed [TAP_W-1:0]  tap;
	logic [PIX_W-1:0]      sel_px;
	logic                  tap_in;
	logic signed [13:0]    prod [3];
	logic signed [TSUM_W-1:0] tsum_eff;
	logic                  out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign ram_we    = (state_q == S_READ);

	rcn_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_above (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_cnt_q),
		.wdata (px_s1),
		.raddr (col_cnt_q),
		.rdata (rd_above)
	);

	rcn_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_two_above (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_cnt_q),
		.wdata (rd_above),
		.raddr (col_cnt_q),
		.rdata (rd_two_above)
	);

	// size registers: zero reads as one, large values saturate
	always_comb begin
		if (width_q == '0) begin
			width_sat = FW_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			width_sat = FW_W'(MAX_WIDTH);
		end else begin
			width_sat = FW_W'(width_q);
		end
		if (height_q == '0) begin
			height_sat = FH_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			height_sat = FH_W'(MAX_HEIGHT);
		end else begin
			height_sat = FH_W'(height_q);
		end
	end

	assign col_last = (FW_W'(col_cnt_q) == frame_w_q - FW_W'(1));
	assign mx_last  = (FW_W'(mx_q) == frame_w_q - FW_W'(1));
	assign my_last  = (FH_W'(my_q) == frame_h_q - FH_W'(1));

	// one tap per MAC cycle, all three channels side by side
	always_comb begin
		tap = $signed(kernel_q[tap_idx_q * TAP_W +: TAP_W]);
		case (dx_q)
			2'd0:    sel_px = win_q[dy_q];
			2'd1:    sel_px = win_q[3 + dy_q];
			default: sel_px = col_q[dy_q];
		endcase
		tap_in = !((dx_q == 2'd0) && (mx_q == '0)) && !((dx_q == 2'd2) && mx_last)
			&& !((dy_q == 2'd0) && (my_q == '0)) && !((dy_q == 2'd2) && my_last);
		prod[0] = tap * $signed({1'b0, sel_px[23:16]});
		prod[1] = tap * $signed({1'b0, sel_px[15:8]});
		prod[2] = tap * $signed({1'b0, sel_px[7:0]});
		tsum_eff = (tsum_q == '0) ? TSUM_W'(1) : tsum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= '0;
			width_q  <= WIDTH_W'(1);
			height_q <= HEIGHT_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KERNEL: kernel_q <= cfg_data[KERNEL_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frame_w_q   <= FW_W'(1);
			frame_h_q   <= FH_W'(1);
			active_q    <= 1'b0;
			col_cnt_q   <= '0;
			prime_q     <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!active_q && in_data.filler) begin
							state_q <= S_IDLE;
						end else begin
							if (!active_q) begin
								frame_w_q <= width_sat;
								frame_h_q <= height_sat;
								active_q  <= 1'b1;
							end
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					col_cnt_q <= col_last ? '0 : col_cnt_q + CI_W'(1);
					if (prime_q < PR_W'(frame_w_q) + PR_W'(1)) begin
						prime_q  <= prime_q + PR_W'(1);
						win_q[0] <= win_q[3];
						win_q[1] <= win_q[4];
						win_q[2] <= win_q[5];
						win_q[3] <= rd_two_above;
						win_q[4] <= rd_above;
						win_q[5] <= px_s1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (tap_idx_q == STEP_W'(TAPS - 1)) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					win_q[0] <= win_q[3];
					win_q[1] <= win_q[4];
					win_q[2] <= win_q[5];
					win_q[3] <= col_q[0];
					win_q[4] <= col_q[1];
					win_q[5] <= col_q[2];
					state_q  <= S_DIV;
				end
				S_DIV: begin
					if (step_q == STEP_W'(MAG_W - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						// last pixel of the frame: start over
						if (mx_last && my_last) begin
							active_q  <= 1'b0;
							col_cnt_q <= '0;
							prime_q   <= '0;
							mx_q      <= '0;
							my_q      <= '0;
						end else if (mx_last) begin
							mx_q <= '0;
							my_q <= my_q + RI_W'(1);
						end else begin
							mx_q <= mx_q + CI_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1 <= in_data.filler ? '0
				: {in_data.red_in, in_data.green_in, in_data.blue_in};
		end
		case (state_q)
			S_READ: begin
				col_q[0]  <= rd_two_above;
				col_q[1]  <= rd_above;
				col_q[2]  <= px_s1;
				dx_q      <= '0;
				dy_q      <= '0;
				tap_idx_q <= '0;
				tsum_q    <= '0;
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= '0;
				end
			end
			S_MAC: begin
				tsum_q <= tsum_q + TSUM_W'(tap);
				for (int c = 0; c < 3; c++) begin
					if (tap_in) begin
						acc_q[c] <= acc_q[c] + ACC_W'(prod[c]);
					end
				end
				tap_idx_q <= tap_idx_q + STEP_W'(1);
				if (dx_q == 2'd2) begin
					dx_q <= '0;
					dy_q <= dy_q + 2'd1;
				end else begin
					dx_q <= dx_q + 2'd1;
				end
			end
			S_PREP: begin
				dvs_q  <= tsum_eff[TSUM_W-1] ? DVS_W'(-tsum_eff) : DVS_W'(tsum_eff);
				step_q <= '0;
				for (int c = 0; c < 3; c++) begin
					neg_q[c] <= acc_q[c][ACC_W-1] ^ tsum_eff[TSUM_W-1];
					rem_q[c] <= '0;
					qd_q[c]  <= acc_q[c][ACC_W-1] ? MAG_W'(-acc_q[c]) : MAG_W'(acc_q[c]);
				end
			end
			S_DIV: begin
				step_q <= step_q + STEP_W'(1);
				// restoring divide, one quotient bit per cycle
				for (int c = 0; c < 3; c++) begin
					if ({rem_q[c], qd_q[c][MAG_W-1]} >= {1'b0, dvs_q}) begin
						rem_q[c] <= DVS_W'({rem_q[c], qd_q[c][MAG_W-1]} - {1'b0, dvs_q});
						qd_q[c]  <= {qd_q[c][MAG_W-2:0], 1'b1};
					end else begin
						rem_q[c] <= DVS_W'({rem_q[c], qd_q[c][MAG_W-1]});
						qd_q[c]  <= {qd_q[c][MAG_W-2:0], 1'b0};
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_q.red_out   <= neg_q[0] ? 8'd0
						: (qd_q[0] > MAG_W'(CH_MAX) ? 8'(CH_MAX) : qd_q[0][7:0]);
					out_q.green_out <= neg_q[1] ? 8'd0
						: (qd_q[1] > MAG_W'(CH_MAX) ? 8'(CH_MAX) : qd_q[1][7:0]);
					out_q.blue_out  <= neg_q[2] ? 8'd0
						: (qd_q[2] > MAG_W'(CH_MAX) ? 8'(CH_MAX) : qd_q[2][7:0]);
					out_q.frame_end <= mx_last && my_last;
				end
			end
			default: ;
		endcase
	end

	`RCN_ASSERT_NOW(a_col_in_row, clk, arst_n, 1'b1, FW_W'(col_cnt_q) < frame_w_q)
	`RCN_ASSERT_NOW(a_mx_in_row, clk, arst_n, 1'b1, FW_W'(mx_q) < frame_w_q)
	`RCN_ASSERT_NEXT(a_div_to_done, clk, arst_n, state_q == S_DIV,
		state_q == S_DIV || state_q == S_DONE)

endmodule

### hw/rtl/rcn_ram.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rcn_ram
// Simple dual-port RAM, one write port, one registered read port.
// ------------------------------------------------------------------------
module rcn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
